@@ design/dawr_pkg.sv @@
// ----------------------------------------------------------------------------
// dawr_pkg: shared types and constants
// Field widths, opcodes, result kinds and history entry types for the
// reliable-datagram sequencing engine.
// ----------------------------------------------------------------------------
package dawr_pkg;

    localparam int SEQ_W     = 16;
    localparam int MASK_W    = 32;
    localparam int AGE_W     = 16;
    localparam int RETRY_W   = 8;
    localparam int KIND_W    = 3;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int SHIFT_W   = 5;

    localparam int ACK_WINDOW  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 6;

    localparam logic [SEQ_W-1:0]   RETRY_INTERVAL_RST = 16'd100;
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST    = 8'd15;

    // Opcodes of an input item
    localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND    = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DUP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SEND   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESEND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IDLE   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [AGE_W-1:0]   age;
        logic [RETRY_W-1:0] retries;
    } entry_t;

    typedef struct packed {
        logic ack_hit;
        logic seq_match;
        logic is_free;
        logic resend;
        logic drop;
        logic age_inc;
    } entry_act_t;

endpackage

@@ design/dawr_entry_unit.sv @@
// ----------------------------------------------------------------------------
// dawr_entry_unit: per-entry decision unit
// Shared compare unit applied to one history entry per cycle: ack match on
// receive, seq match and free check on send, age, resend and drop on tick.
// ----------------------------------------------------------------------------
module dawr_entry_unit
(
    input  logic [dawr_pkg::OP_W-1:0]    op,
    input  logic                         ent_valid,
    input  dawr_pkg::entry_t             ent,
    input  logic [dawr_pkg::SEQ_W-1:0]   peer_ack,
    input  logic [dawr_pkg::MASK_W-1:0]  peer_ack_mask,
    input  logic [dawr_pkg::SEQ_W-1:0]   send_seq,
    input  logic [dawr_pkg::SEQ_W-1:0]   retry_interval,
    input  logic [dawr_pkg::RETRY_W-1:0] max_retries,
    input  logic                         resend_cap,
    output dawr_pkg::entry_act_t         act,
    output dawr_pkg::entry_t             upd
);

    logic [dawr_pkg::SEQ_W-1:0] diff;
    logic [dawr_pkg::SEQ_W-1:0] diff_m1;
    logic                       in_window;
    logic                       due;
    logic                       can_retry;

    assign diff      = peer_ack - ent.seq;
    assign diff_m1   = diff - 16'd1;
    assign in_window = (diff != '0)
                    && (diff <= dawr_pkg::SEQ_W'(dawr_pkg::ACK_WINDOW));
    assign due       = (ent.age >= retry_interval);
    assign can_retry = (ent.retries < max_retries);

    always_comb
    begin
        act = '0;
        upd = ent;
        unique case (op)
            dawr_pkg::OP_RECEIVE:
            begin
                act.ack_hit = ent_valid && ((diff == '0)
                           || (in_window && peer_ack_mask[diff_m1[dawr_pkg::SHIFT_W-1:0]]));
            end
            dawr_pkg::OP_SEND:
            begin
                act.seq_match = ent_valid && (ent.seq == send_seq);
                act.is_free   = !ent_valid;
            end
            dawr_pkg::OP_TICK:
            begin
                act.resend  = ent_valid && due && can_retry && !resend_cap;
                act.drop    = ent_valid && due && !can_retry;
                act.age_inc = ent_valid && !due && (ent.age != '1);
                if (act.resend)
                begin
                    upd.age     = '0;
                    upd.retries = ent.retries + 8'd1;
                end
                else if (act.age_inc)
                begin
                    upd.age = ent.age + 16'd1;
                end
            end
            default:
            begin
                act = '0;
            end
        endcase
    end

endmodule

@@ design/datagram_ack_window_retransmit_unit.sv @@
// ----------------------------------------------------------------------------
// datagram_ack_window_retransmit_unit: reliable-datagram sequencing engine
// Tracks the receive ack window, assigns send sequence numbers and keeps a
// retransmit history that is scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive opcode and its fields with start high; the item is
//   taken at the edge where start is high and busy is low. busy then stays
//   high until all results of the item are out.
//   Result channel: each result is on the result ports for one cycle with
//   result_valid high; last marks the final result of an item. Results are
//   never held back, so the receiver must take each one as it appears.
//   Config: cfg_we, cfg_index, cfg_data write retry_interval (index 0) or
//   max_retries (index 1); write only while busy is low.
//   Walk: every item walks the whole history once through a single shared
//   entry unit and one memory read port, one entry per cycle. busy is low
//   while the last result of an item is on the result ports, so the next
//   item can be taken at the edge that takes that result, never before.
//   Resends of a tick come out during the walk: each is held until the next
//   one is found or the walk ends, so that the final one can carry last.
//   Reset: clears the sequence counter, the receive window and all history
//   valid bits, and loads the configuration defaults. No clearing pass is
//   needed; entry contents are read only behind their valid bits.
// ----------------------------------------------------------------------------
module datagram_ack_window_retransmit_unit
#(
    parameter int HISTORY_DEPTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cfg_we,
    input  logic [dawr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dawr_pkg::CFG_W-1:0]     cfg_data,
    input  logic [dawr_pkg::OP_W-1:0]      opcode,
    input  logic [dawr_pkg::SEQ_W-1:0]     rx_seq,
    input  logic [dawr_pkg::SEQ_W-1:0]     peer_ack,
    input  logic [dawr_pkg::MASK_W-1:0]    peer_ack_mask,
    input  logic                           reliable,
    output logic                           result_valid,
    output logic [dawr_pkg::KIND_W-1:0]    kind,
    output logic [dawr_pkg::SEQ_W-1:0]     seq_out,
    output logic [dawr_pkg::SEQ_W-1:0]     ack_out,
    output logic [dawr_pkg::MASK_W-1:0]    ack_mask_out,
    output logic                           history_full,
    output logic                           last
);

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    // Control and configuration
    state_t                          state_reg, state_next;
    logic [dawr_pkg::SEQ_W-1:0]      retry_interval_reg, retry_interval_next;
    logic [dawr_pkg::RETRY_W-1:0]    max_retries_reg, max_retries_next;

    // Protocol state
    logic [dawr_pkg::SEQ_W-1:0]      next_sequence_reg, next_sequence_next;
    logic [dawr_pkg::SEQ_W-1:0]      latest_reg, latest_next;
    logic [dawr_pkg::MASK_W-1:0]     rmask_reg, rmask_next;
    logic [HISTORY_DEPTH-1:0]        valid_reg, valid_next;

    // Latched input item
    logic [dawr_pkg::OP_W-1:0]       op_reg, op_next;
    logic [dawr_pkg::SEQ_W-1:0]      rx_reg, rx_next;
    logic [dawr_pkg::SEQ_W-1:0]      pack_reg, pack_next;
    logic [dawr_pkg::MASK_W-1:0]     pmask_reg, pmask_next;
    logic                            rel_reg, rel_next;

    // Scan sequencer
    logic [IDX_W-1:0]                scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]                eval_idx_reg, eval_idx_next;
    logic                            eval_v_reg, eval_v_next;
    logic                            match_found_reg, match_found_next;
    logic [IDX_W-1:0]                match_idx_reg, match_idx_next;
    logic                            free_found_reg, free_found_next;
    logic [IDX_W-1:0]                free_idx_reg, free_idx_next;
    logic                            pend_v_reg, pend_v_next;
    logic [dawr_pkg::SEQ_W-1:0]      pend_seq_reg, pend_seq_next;
    logic [dawr_pkg::CNT_W-1:0]      res_cnt_reg, res_cnt_next;

    // Result registers
    logic                            result_valid_reg, result_valid_next;
    logic [dawr_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [dawr_pkg::SEQ_W-1:0]      seq_out_reg, seq_out_next;
    logic [dawr_pkg::SEQ_W-1:0]      ack_out_reg, ack_out_next;
    logic [dawr_pkg::MASK_W-1:0]     ack_mask_out_reg, ack_mask_out_next;
    logic                            history_full_reg, history_full_next;
    logic                            last_reg, last_next;

    // History memory
    dawr_pkg::entry_t                entry_mem [HISTORY_DEPTH];
    dawr_pkg::entry_t                mem_q_reg;
    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    dawr_pkg::entry_t                mem_wdata;

    // Entry unit
    dawr_pkg::entry_act_t            act;
    dawr_pkg::entry_t                upd;
    logic [dawr_pkg::SEQ_W-1:0]      send_seq;
    logic                            resend_cap;

    // Receive window
    logic [dawr_pkg::SEQ_W-1:0]      fwd, fwd_m1, back, back_m1;
    logic [dawr_pkg::SEQ_W-1:0]      win_latest;
    logic [dawr_pkg::MASK_W-1:0]     win_mask;
    logic [dawr_pkg::MASK_W-1:0]     win_bit;
    logic                            win_dup;
    logic [IDX_W-1:0]                slot;

    assign send_seq   = next_sequence_reg + 16'd1;
    assign resend_cap = (res_cnt_reg == dawr_pkg::CNT_W'(dawr_pkg::MAX_RESULTS));
    assign slot       = match_found_reg ? match_idx_reg : free_idx_reg;

    dawr_entry_unit u_entry
    (
        .op             (op_reg),
        .ent_valid      (valid_reg[eval_idx_reg]),
        .ent            (mem_q_reg),
        .peer_ack       (pack_reg),
        .peer_ack_mask  (pmask_reg),
        .send_seq       (send_seq),
        .retry_interval (retry_interval_reg),
        .max_retries    (max_retries_reg),
        .resend_cap     (resend_cap),
        .act            (act),
        .upd            (upd)
    );

    // Move the ack window for a received sequence, with 16-bit wraparound
    always_comb
    begin
        fwd        = rx_reg - latest_reg;
        fwd_m1     = fwd - 16'd1;
        back       = latest_reg - rx_reg;
        back_m1    = back - 16'd1;
        win_latest = latest_reg;
        win_mask   = rmask_reg;
        win_bit    = '0;
        win_dup    = 1'b0;
        if (fwd == '0)
        begin
            win_dup = 1'b1;
        end
        else if (!fwd[dawr_pkg::SEQ_W-1])
        begin
            win_latest = rx_reg;
            if (fwd <= dawr_pkg::SEQ_W'(dawr_pkg::ACK_WINDOW))
            begin
                win_bit  = dawr_pkg::MASK_W'(1) << fwd_m1[dawr_pkg::SHIFT_W-1:0];
                win_mask = win_bit;
                if (fwd < dawr_pkg::SEQ_W'(dawr_pkg::ACK_WINDOW))
                begin
                    win_mask = win_bit | (rmask_reg << fwd[dawr_pkg::SHIFT_W-1:0]);
                end
            end
            else
            begin
                win_mask = '0;
            end
        end
        else if (back <= dawr_pkg::SEQ_W'(dawr_pkg::ACK_WINDOW))
        begin
            win_bit  = dawr_pkg::MASK_W'(1) << back_m1[dawr_pkg::SHIFT_W-1:0];
            win_dup  = |(rmask_reg & win_bit);
            win_mask = rmask_reg | win_bit;
        end
        else
        begin
            win_dup = 1'b1;
        end
    end

    // Memory write: aging and resend updates during a tick walk, new entry at
    // the end of a reliable send
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = eval_idx_reg;
        mem_wdata = upd;
        if (eval_v_reg && (op_reg == dawr_pkg::OP_TICK) && (act.resend || act.age_inc))
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == S_FINISH) && (op_reg == dawr_pkg::OP_SEND) && rel_reg
                 && (match_found_reg || free_found_reg))
        begin
            mem_we            = 1'b1;
            mem_waddr         = slot;
            mem_wdata.seq     = send_seq;
            mem_wdata.age     = '0;
            mem_wdata.retries = '0;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        retry_interval_next = retry_interval_reg;
        max_retries_next    = max_retries_reg;
        next_sequence_next  = next_sequence_reg;
        latest_next         = latest_reg;
        rmask_next          = rmask_reg;
        valid_next          = valid_reg;
        op_next             = op_reg;
        rx_next             = rx_reg;
        pack_next           = pack_reg;
        pmask_next          = pmask_reg;
        rel_next            = rel_reg;
        scan_idx_next       = scan_idx_reg;
        eval_idx_next       = eval_idx_reg;
        eval_v_next         = eval_v_reg;
        match_found_next    = match_found_reg;
        match_idx_next      = match_idx_reg;
        free_found_next     = free_found_reg;
        free_idx_next       = free_idx_reg;
        pend_v_next         = pend_v_reg;
        pend_seq_next       = pend_seq_reg;
        res_cnt_next        = res_cnt_reg;
        result_valid_next   = 1'b0;
        kind_next           = kind_reg;
        seq_out_next        = seq_out_reg;
        ack_out_next        = ack_out_reg;
        ack_mask_out_next   = ack_mask_out_reg;
        history_full_next   = 1'b0;
        last_next           = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                dawr_pkg::CFG_RETRY_INTERVAL: retry_interval_next = cfg_data;
                dawr_pkg::CFG_MAX_RETRIES:
                    max_retries_next = cfg_data[dawr_pkg::RETRY_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next          = opcode;
                    rx_next          = rx_seq;
                    pack_next        = peer_ack;
                    pmask_next       = peer_ack_mask;
                    rel_next         = reliable;
                    scan_idx_next    = '0;
                    eval_v_next      = 1'b0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    pend_v_next      = 1'b0;
                    res_cnt_next     = '0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                eval_v_next   = 1'b1;
                eval_idx_next = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                eval_v_next = 1'b0;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                result_valid_next = 1'b1;
                last_next         = 1'b1;
                state_next        = S_IDLE;
                unique case (op_reg)
                    dawr_pkg::OP_RECEIVE:
                    begin
                        latest_next       = win_latest;
                        rmask_next        = win_mask;
                        kind_next         = win_dup ? dawr_pkg::KIND_DUP
                                                    : dawr_pkg::KIND_ACCEPT;
                        seq_out_next      = rx_reg;
                        ack_out_next      = win_latest;
                        ack_mask_out_next = win_mask;
                    end
                    dawr_pkg::OP_SEND:
                    begin
                        next_sequence_next = send_seq;
                        if (rel_reg)
                        begin
                            if (match_found_reg || free_found_reg)
                            begin
                                valid_next[slot] = 1'b1;
                            end
                            else
                            begin
                                history_full_next = 1'b1;
                            end
                        end
                        kind_next         = dawr_pkg::KIND_SEND;
                        seq_out_next      = send_seq;
                        ack_out_next      = latest_reg;
                        ack_mask_out_next = rmask_reg;
                    end
                    dawr_pkg::OP_TICK:
                    begin
                        kind_next         = pend_v_reg ? dawr_pkg::KIND_RESEND
                                                       : dawr_pkg::KIND_IDLE;
                        seq_out_next      = pend_v_reg ? pend_seq_reg : '0;
                        ack_out_next      = '0;
                        ack_mask_out_next = '0;
                    end
                    default:
                    begin
                        kind_next         = dawr_pkg::KIND_IDLE;
                        seq_out_next      = '0;
                        ack_out_next      = '0;
                        ack_mask_out_next = '0;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Act on the entry read out of the memory last cycle
        if (eval_v_reg)
        begin
            unique case (op_reg)
                dawr_pkg::OP_RECEIVE:
                begin
                    if (act.ack_hit)
                    begin
                        valid_next[eval_idx_reg] = 1'b0;
                    end
                end
                dawr_pkg::OP_SEND:
                begin
                    if (rel_reg && act.seq_match && !match_found_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = eval_idx_reg;
                    end
                    if (rel_reg && act.is_free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = eval_idx_reg;
                    end
                end
                dawr_pkg::OP_TICK:
                begin
                    if (act.resend)
                    begin
                        // Release the held resend; the newest one waits so
                        // that the final one can carry last
                        if (pend_v_reg)
                        begin
                            result_valid_next = 1'b1;
                            kind_next         = dawr_pkg::KIND_RESEND;
                            seq_out_next      = pend_seq_reg;
                            ack_out_next      = '0;
                            ack_mask_out_next = '0;
                        end
                        pend_v_next   = 1'b1;
                        pend_seq_next = mem_q_reg.seq;
                        res_cnt_next  = res_cnt_reg + 1'b1;
                    end
                    if (act.drop)
                    begin
                        valid_next[eval_idx_reg] = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            retry_interval_reg <= dawr_pkg::RETRY_INTERVAL_RST;
            max_retries_reg    <= dawr_pkg::MAX_RETRIES_RST;
            next_sequence_reg  <= '0;
            latest_reg         <= '0;
            rmask_reg          <= '0;
            valid_reg          <= '0;
            op_reg             <= '0;
            rx_reg             <= '0;
            pack_reg           <= '0;
            pmask_reg          <= '0;
            rel_reg            <= 1'b0;
            scan_idx_reg       <= '0;
            eval_idx_reg       <= '0;
            eval_v_reg         <= 1'b0;
            match_found_reg    <= 1'b0;
            match_idx_reg      <= '0;
            free_found_reg     <= 1'b0;
            free_idx_reg       <= '0;
            pend_v_reg         <= 1'b0;
            pend_seq_reg       <= '0;
            res_cnt_reg        <= '0;
            result_valid_reg   <= 1'b0;
            kind_reg           <= '0;
            seq_out_reg        <= '0;
            ack_out_reg        <= '0;
            ack_mask_out_reg   <= '0;
            history_full_reg   <= 1'b0;
            last_reg           <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            retry_interval_reg <= retry_interval_next;
            max_retries_reg    <= max_retries_next;
            next_sequence_reg  <= next_sequence_next;
            latest_reg         <= latest_next;
            rmask_reg          <= rmask_next;
            valid_reg          <= valid_next;
            op_reg             <= op_next;
            rx_reg             <= rx_next;
            pack_reg           <= pack_next;
            pmask_reg          <= pmask_next;
            rel_reg            <= rel_next;
            scan_idx_reg       <= scan_idx_next;
            eval_idx_reg       <= eval_idx_next;
            eval_v_reg         <= eval_v_next;
            match_found_reg    <= match_found_next;
            match_idx_reg      <= match_idx_next;
            free_found_reg     <= free_found_next;
            free_idx_reg       <= free_idx_next;
            pend_v_reg         <= pend_v_next;
            pend_seq_reg       <= pend_seq_next;
            res_cnt_reg        <= res_cnt_next;
            result_valid_reg   <= result_valid_next;
            kind_reg           <= kind_next;
            seq_out_reg        <= seq_out_next;
            ack_out_reg        <= ack_out_next;
            ack_mask_out_reg   <= ack_mask_out_next;
            history_full_reg   <= history_full_next;
            last_reg           <= last_next;
        end
    end

    // History memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= entry_mem[scan_idx_reg];
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign seq_out      = seq_out_reg;
    assign ack_out      = ack_out_reg;
    assign ack_mask_out = ack_mask_out_reg;
    assign history_full = history_full_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
    else $error("accepted item did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
    else $error("result emitted right after the final result of an item");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == dawr_pkg::KIND_SEND || kind == dawr_pkg::KIND_ACCEPT
                         || kind == dawr_pkg::KIND_DUP) |-> last)
    else $error("single-result item without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        history_full |-> result_valid && kind == dawr_pkg::KIND_SEND)
    else $error("history_full outside a send result");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy && kind == dawr_pkg::KIND_RESEND)
    else $error("non-final result outside a tick walk");
`endif

endmodule

@@ test/tb_datagram_ack_window_retransmit_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_datagram_ack_window_retransmit_unit: sequencing engine regression
// Drives received packets, sends and ticks through the command
// port and tracks the ack window and retransmit history in a local model.
// Every result strobe is checked in order against the model's expected
// results. Runs directed window and retry cases, a history overflow, then
// random traffic under several retry settings.
// ----------------------------------------------------------------------------
module tb_datagram_ack_window_retransmit_unit;

    localparam int HIST_DEPTH  = 32;
    localparam int ITEM_CYCLES = HIST_DEPTH + 3;
    localparam int MAX_REPORTS = 10;

    // The opcode space has one unused code; the block answers it with tick idle
    localparam logic [dawr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [dawr_pkg::KIND_W-1:0] kind;
        logic [dawr_pkg::SEQ_W-1:0]  seq;
        logic [dawr_pkg::SEQ_W-1:0]  ack;
        logic [dawr_pkg::MASK_W-1:0] mask;
        logic                        full;
        logic                        last;
    } hdr_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic                            cfg_we;
    logic [dawr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dawr_pkg::CFG_W-1:0]      cfg_data;
    logic [dawr_pkg::OP_W-1:0]       opcode;
    logic [dawr_pkg::SEQ_W-1:0]      rx_seq;
    logic [dawr_pkg::SEQ_W-1:0]      peer_ack;
    logic [dawr_pkg::MASK_W-1:0]     peer_ack_mask;
    logic                            reliable;
    logic                            result_valid;
    logic [dawr_pkg::KIND_W-1:0]     kind;
    logic [dawr_pkg::SEQ_W-1:0]      seq_out;
    logic [dawr_pkg::SEQ_W-1:0]      ack_out;
    logic [dawr_pkg::MASK_W-1:0]     ack_mask_out;
    logic                            history_full;
    logic                            last;

    // Model of the engine state, updated at the edge that takes each item
    logic [dawr_pkg::SEQ_W-1:0]      nxt_seq;
    logic [dawr_pkg::SEQ_W-1:0]      rx_latest;
    logic [dawr_pkg::MASK_W-1:0]     rx_mask;
    logic                            hist_valid [HIST_DEPTH];
    logic [dawr_pkg::SEQ_W-1:0]      hist_seq   [HIST_DEPTH];
    logic [dawr_pkg::AGE_W-1:0]      hist_age   [HIST_DEPTH];
    logic [dawr_pkg::RETRY_W-1:0]    hist_tries [HIST_DEPTH];
    logic [dawr_pkg::SEQ_W-1:0]      cfg_retry_int;
    logic [dawr_pkg::RETRY_W-1:0]    cfg_max_tries;

    hdr_result_t                     pending_results [$];
    int                              mismatches = 0;

    // Stimulus-side view: sends issued and the newest forward rx sequence
    logic [dawr_pkg::SEQ_W-1:0]      tx_count;
    logic [dawr_pkg::SEQ_W-1:0]      rx_cursor;

    datagram_ack_window_retransmit_unit
    #(
        .HISTORY_DEPTH (HIST_DEPTH)
    )
    i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .rx_seq        (rx_seq),
        .peer_ack      (peer_ack),
        .peer_ack_mask (peer_ack_mask),
        .reliable      (reliable),
        .result_valid  (result_valid),
        .kind          (kind),
        .seq_out       (seq_out),
        .ack_out       (ack_out),
        .ack_mask_out  (ack_mask_out),
        .history_full  (history_full),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model: work out the results of one item and queue them in order
    // ------------------------------------------------------------------------
    function automatic void compute_item_results(
        input logic [dawr_pkg::OP_W-1:0]   op,
        input logic [dawr_pkg::SEQ_W-1:0]  rx,
        input logic [dawr_pkg::SEQ_W-1:0]  pack,
        input logic [dawr_pkg::MASK_W-1:0] pmask,
        input logic                        rel);
        hdr_result_t                 outs [dawr_pkg::MAX_RESULTS];
        int                          n;
        int                          i;
        int                          slot;
        logic                        dup;
        logic                        full;
        logic [dawr_pkg::SEQ_W-1:0]  fwd;
        logic [dawr_pkg::SEQ_W-1:0]  back;
        logic [dawr_pkg::SEQ_W-1:0]  ack_dist;
        logic [dawr_pkg::MASK_W-1:0] bitm;

        n = 0;
        case (op)
            dawr_pkg::OP_RECEIVE:
            begin
                dup = 1'b0;
                fwd = rx - rx_latest;
                if (fwd == 16'd0)
                begin
                    dup = 1'b1;
                end
                else if (fwd < 16'h8000)
                begin
                    // Slide the window forward; a jump past it empties the mask
                    if (fwd <= 16'd32)
                        rx_mask = ((fwd < 16'd32) ? (rx_mask << fwd) : 32'd0)
                                  | (32'd1 << (fwd - 16'd1));
                    else
                        rx_mask = 32'd0;
                    rx_latest = rx;
                end
                else
                begin
                    // Older packet: mark it inside the window, else call it a duplicate
                    back = rx_latest - rx;
                    if (back <= 16'd32)
                    begin
                        bitm = 32'd1 << (back - 16'd1);
                        if ((rx_mask & bitm) != 32'd0)
                            dup = 1'b1;
                        rx_mask = rx_mask | bitm;
                    end
                    else
                    begin
                        dup = 1'b1;
                    end
                end
                // Drop every history entry that the peer acknowledges
                for (i = 0; i < HIST_DEPTH; i++)
                begin
                    if (hist_valid[i])
                    begin
                        ack_dist = pack - hist_seq[i];
                        if (ack_dist == 16'd0
                            || (ack_dist <= 16'd32 && pmask[5'(ack_dist - 16'd1)]))
                            hist_valid[i] = 1'b0;
                    end
                end
                outs[0] = '{dup ? dawr_pkg::KIND_DUP : dawr_pkg::KIND_ACCEPT,
                            rx, rx_latest, rx_mask, 1'b0, 1'b0};
                n = 1;
            end
            dawr_pkg::OP_SEND:
            begin
                nxt_seq = nxt_seq + 16'd1;
                full    = 1'b0;
                slot    = -1;
                if (rel)
                begin
                    // Reuse an entry with the same sequence, else take the lowest free one
                    for (i = 0; i < HIST_DEPTH; i++)
                        if (slot < 0 && hist_valid[i] && hist_seq[i] == nxt_seq)
                            slot = i;
                    for (i = 0; i < HIST_DEPTH; i++)
                        if (slot < 0 && !hist_valid[i])
                            slot = i;
                    if (slot < 0)
                    begin
                        full = 1'b1;
                    end
                    else
                    begin
                        hist_valid[slot] = 1'b1;
                        hist_seq[slot]   = nxt_seq;
                        hist_age[slot]   = '0;
                        hist_tries[slot] = '0;
                    end
                end
                outs[0] = '{dawr_pkg::KIND_SEND, nxt_seq, rx_latest, rx_mask, full, 1'b0};
                n = 1;
            end
            dawr_pkg::OP_TICK:
            begin
                // Scan from the lowest slot: resend due entries, drop spent ones, age the rest
                for (i = 0; i < HIST_DEPTH; i++)
                begin
                    if (hist_valid[i])
                    begin
                        if (hist_age[i] >= cfg_retry_int)
                        begin
                            if (hist_tries[i] < cfg_max_tries)
                            begin
                                if (n < dawr_pkg::MAX_RESULTS)
                                begin
                                    outs[n] = '{dawr_pkg::KIND_RESEND, hist_seq[i],
                                                16'd0, 32'd0, 1'b0, 1'b0};
                                    n++;
                                    hist_age[i]   = '0;
                                    hist_tries[i] = hist_tries[i] + 8'd1;
                                end
                            end
                            else
                            begin
                                hist_valid[i] = 1'b0;
                            end
                        end
                        else if (hist_age[i] != 16'hFFFF)
                        begin
                            hist_age[i] = hist_age[i] + 16'd1;
                        end
                    end
                end
                if (n == 0)
                begin
                    outs[0] = '{dawr_pkg::KIND_IDLE, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0};
                    n = 1;
                end
            end
            default:
            begin
                outs[0] = '{dawr_pkg::KIND_IDLE, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0};
                n = 1;
            end
        endcase
        for (i = 0; i < n; i++)
        begin
            outs[i].last = (i == n - 1);
            pending_results.push_back(outs[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check each result strobe, track register writes, and predict
    // every item the block takes. All inputs are sampled at the clock edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        hdr_result_t got;
        hdr_result_t want;
        int          i;

        if (!rst_n)
        begin
            nxt_seq       = '0;
            rx_latest     = '0;
            rx_mask       = '0;
            cfg_retry_int = dawr_pkg::RETRY_INTERVAL_RST;
            cfg_max_tries = dawr_pkg::MAX_RETRIES_RST;
            for (i = 0; i < HIST_DEPTH; i++)
                hist_valid[i] = 1'b0;
        end
        else
        begin
            if (result_valid)
            begin
                got = {kind, seq_out, ack_out, ack_mask_out, history_full, last};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%t: unexpected result kind %0d seq %h ack %h mask %h %s",
                                 $realtime, got.kind, got.seq, got.ack, got.mask,
                                 $sformatf("full %b last %b", got.full, got.last));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%t: result mismatch (expected/actual) %s %s",
                                     $realtime,
                                     $sformatf("kind %0d/%0d seq %h/%h ack %h/%h",
                                               want.kind, got.kind, want.seq, got.seq,
                                               want.ack, got.ack),
                                     $sformatf("mask %h/%h full %b/%b last %b/%b",
                                               want.mask, got.mask, want.full, got.full,
                                               want.last, got.last));
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == dawr_pkg::CFG_RETRY_INTERVAL)
                    cfg_retry_int = cfg_data;
                else
                    cfg_max_tries = cfg_data[dawr_pkg::RETRY_W-1:0];
            end
            if (start && !busy)
                compute_item_results(opcode, rx_seq, peer_ack, peer_ack_mask, reliable);
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Present one item and hold it until the block takes it
    task automatic send_item(input logic [dawr_pkg::OP_W-1:0]   op,
                             input logic [dawr_pkg::SEQ_W-1:0]  rx,
                             input logic [dawr_pkg::SEQ_W-1:0]  pack,
                             input logic [dawr_pkg::MASK_W-1:0] pmask,
                             input logic                        rel);
        logic [dawr_pkg::SEQ_W-1:0] fwd;

        start         <= 1'b1;
        opcode        <= op;
        rx_seq        <= rx;
        peer_ack      <= pack;
        peer_ack_mask <= pmask;
        reliable      <= rel;
        if (op == dawr_pkg::OP_SEND)
            tx_count = tx_count + 16'd1;
        if (op == dawr_pkg::OP_RECEIVE)
        begin
            fwd = rx - rx_cursor;
            if (fwd != 16'd0 && fwd < 16'h8000)
                rx_cursor = rx;
        end
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold start low for a random burst
    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 14))
            @(posedge clk);
    endtask

    // Hold off until every queued result has come and the block is idle
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Write both retry registers while the block is idle
    task automatic set_retry_policy(input logic [dawr_pkg::SEQ_W-1:0]   interval,
                                    input logic [dawr_pkg::RETRY_W-1:0] tries);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= dawr_pkg::CFG_RETRY_INTERVAL;
        cfg_data  <= interval;
        @(posedge clk);
        cfg_index <= dawr_pkg::CFG_MAX_RETRIES;
        cfg_data  <= {8'($urandom), tries};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random item, biased toward in-order traffic near the live window
    task automatic random_item();
        int                          pick;
        int                          sel;
        logic [dawr_pkg::SEQ_W-1:0]  rx;
        logic [dawr_pkg::SEQ_W-1:0]  pack;
        logic [dawr_pkg::MASK_W-1:0] pmask;

        pick  = $urandom_range(0, 99);
        rx    = 16'($urandom);
        pmask = $urandom;
        if ($urandom_range(0, 2) == 0)
            pmask = pmask & $urandom;
        // Ack mostly recent sends so history entries get cleared
        pack = tx_count - 16'($urandom_range(0, 40));
        if ($urandom_range(0, 9) == 0)
            pack = 16'($urandom);
        if (pick < 40)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                rx = rx_cursor + 16'($urandom_range(1, 3));
            else if (sel < 75)
                rx = rx_cursor - 16'($urandom_range(1, 33));
            else if (sel < 82)
                rx = rx_cursor;
            else if (sel >= 92)
                rx = rx_cursor + 16'($urandom_range(32, 40));
            send_item(dawr_pkg::OP_RECEIVE, rx, pack, pmask, 1'($urandom));
        end
        else if (pick < 75)
        begin
            send_item(dawr_pkg::OP_SEND, rx, pack, pmask, $urandom_range(0, 9) < 7);
        end
        else if (pick < 97)
        begin
            send_item(dawr_pkg::OP_TICK, rx, pack, pmask, 1'($urandom));
        end
        else
        begin
            send_item(OP_UNUSED, rx, pack, pmask, 1'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Window edges, wraparound, acks by mask and the unused opcode
    task automatic test_receive_window();
        // initial window: sequence 0 equals the reset latest, so a duplicate
        send_item(dawr_pkg::OP_RECEIVE, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
        send_item(OP_UNUSED,            16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(dawr_pkg::OP_SEND,    16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
        send_item(dawr_pkg::OP_SEND,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(dawr_pkg::OP_SEND,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1);
        send_item(dawr_pkg::OP_RECEIVE, 16'd1,    16'h0000, 32'h0000_0000, 1'b0);
        // jump of exactly the window: the old latest lands in the top bit
        send_item(dawr_pkg::OP_RECEIVE, 16'd33,   16'h0000, 32'h0000_0000, 1'b0);
        // larger jump clears the mask
        send_item(dawr_pkg::OP_RECEIVE, 16'd1000, 16'h0000, 32'h0000_0000, 1'b0);
        send_item(dawr_pkg::OP_RECEIVE, 16'd999,  16'h0000, 32'h0000_0000, 1'b0);
        send_item(dawr_pkg::OP_RECEIVE, 16'd999,  16'h0000, 32'h0000_0000, 1'b0);
        send_item(dawr_pkg::OP_RECEIVE, 16'd968,  16'h0000, 32'h0000_0000, 1'b0);
        // far old packets: one past the window, then exactly half the space back
        send_item(dawr_pkg::OP_RECEIVE, 16'd967,  16'h0000, 32'h0000_0000, 1'b0);
        send_item(dawr_pkg::OP_RECEIVE, 16'd33768, 16'h0000, 32'h0000_0000, 1'b0);
        send_item(dawr_pkg::OP_RECEIVE, 16'd33767, 16'h0000, 32'h0000_0000, 1'b0);
        send_item(dawr_pkg::OP_RECEIVE, 16'hFFFF, 16'h0000, 32'h0000_0000, 1'b0);
        // wrap to zero; ack 3 directly and 2 through mask bit 0
        send_item(dawr_pkg::OP_RECEIVE, 16'h0000, 16'd3,    32'h0000_0001, 1'b0);
        send_item(dawr_pkg::OP_TICK,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(dawr_pkg::OP_SEND,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1);
        // mask bit 31 acknowledges the sequence a full window behind peer_ack
        send_item(dawr_pkg::OP_RECEIVE, 16'd4,    16'd36,   32'h8000_0000, 1'b0);
        send_item(dawr_pkg::OP_TICK,    16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    endtask

    // Resend after the interval and drop once retries are spent
    task automatic test_retry_limits();
        int k;

        set_retry_policy(16'd1, 8'd2);
        send_item(dawr_pkg::OP_SEND, 16'h0000, 16'h0000, 32'h0, 1'b1);
        send_item(dawr_pkg::OP_SEND, 16'h0000, 16'h0000, 32'h0, 1'b1);
        for (k = 0; k < 6; k++)
            send_item(dawr_pkg::OP_TICK, 16'($urandom), 16'($urandom), $urandom,
                      1'($urandom));
        // no retries allowed: a due entry goes silently
        set_retry_policy(16'd3, 8'd0);
        send_item(dawr_pkg::OP_SEND, 16'h0000, 16'h0000, 32'h0, 1'b1);
        for (k = 0; k < 5; k++)
            send_item(dawr_pkg::OP_TICK, 16'($urandom), 16'($urandom), $urandom,
                      1'($urandom));
        set_retry_policy(16'hFFFF, 8'hFF);
        send_item(dawr_pkg::OP_SEND, 16'h0000, 16'h0000, 32'h0, 1'b1);
        send_item(dawr_pkg::OP_SEND, 16'h0000, 16'h0000, 32'h0, 1'b1);
        for (k = 0; k < 3; k++)
            send_item(dawr_pkg::OP_TICK, 16'($urandom), 16'($urandom), $urandom,
                      1'($urandom));
    endtask

    // Fill the history, overflow it, then take a full tick of resends
    task automatic test_history_overflow();
        int k;

        // Flush whatever is left: everything becomes due and is dropped
        set_retry_policy(16'd1, 8'd0);
        send_item(dawr_pkg::OP_TICK, 16'h0000, 16'h0000, 32'h0, 1'b0);
        send_item(dawr_pkg::OP_TICK, 16'h0000, 16'h0000, 32'h0, 1'b0);
        set_retry_policy(16'd1, 8'd1);
        for (k = 0; k < HIST_DEPTH + 1; k++)
            send_item(dawr_pkg::OP_SEND, 16'($urandom), 16'($urandom), $urandom, 1'b1);
        // age, resend all, age, drop all
        for (k = 0; k < 4; k++)
            send_item(dawr_pkg::OP_TICK, 16'($urandom), 16'($urandom), $urandom,
                      1'($urandom));
    endtask

    // Random traffic; optional idle bursts and an occasional full drain
    task automatic test_random_traffic(input int n_items, input bit with_gaps);
        int k;

        for (k = 0; k < n_items; k++)
        begin
            random_item();
            if (with_gaps && $urandom_range(0, 3) == 0)
                idle_burst();
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = dawr_pkg::CFG_RETRY_INTERVAL;
        cfg_data      = '0;
        opcode        = dawr_pkg::OP_RECEIVE;
        rx_seq        = '0;
        peer_ack      = '0;
        peer_ack_mask = '0;
        reliable      = 1'b0;
        tx_count      = '0;
        rx_cursor     = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_receive_window();
        test_retry_limits();
        test_history_overflow();

        // Short intervals and few retries keep resends and drops frequent
        set_retry_policy(16'($urandom_range(1, 4)), 8'($urandom_range(0, 3)));
        test_random_traffic(50, 1'b1);
        set_retry_policy(16'hFFFF, 8'hFF);
        test_random_traffic(30, 1'b1);
        set_retry_policy(16'd2, 8'hFF);
        test_random_traffic(40, 1'b1);
        // Last stretch runs back to back with no idle bursts
        set_retry_policy(16'($urandom_range(1, 6)), 8'($urandom_range(1, 5)));
        test_random_traffic(52, 1'b0);

        drain_results();
        repeat (2 * ITEM_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("datagram_ack_window_retransmit_unit regression: pass");
        else
            $display("datagram_ack_window_retransmit_unit regression: fail");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #5_000_000;
        $display("datagram_ack_window_retransmit_unit regression: fail");
        $finish;
    end

endmodule
